/* rtl/bgps_pkg.sv */
// Shared codes, widths and status type for the biped gait phase scheduler.
package bgps_pkg;

  localparam int DEF_PHASE_FRAC_BITS = 16;
  localparam int FZ_W                = 24;
  localparam int STEPS_W             = 16;
  localparam int CFG_ADDR_W          = 5;
  localparam int CFG_DATA_W          = 32;

  // stance codes
  localparam logic [1:0] LEG_DS = 2'd0;
  localparam logic [1:0] LEG_L  = 2'd1;
  localparam logic [1:0] LEG_R  = 2'd2;

  // motion modes
  localparam logic [1:0] MODE_STAND = 2'd0;
  localparam logic [1:0] MODE_WALK  = 2'd1;
  localparam logic [1:0] MODE_W2S   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_PHI_MIN    = 3'd1;
  localparam logic [2:0] REG_FZ_SWITCH  = 3'd2;
  localparam logic [2:0] REG_FZ_STOP    = 3'd3;
  localparam logic [2:0] REG_FIRST_LEG  = 3'd4;

  localparam logic [FZ_W-1:0] FZ_THRESH_RST = FZ_W'(10000);

  typedef struct packed {
    logic [1:0] leg_phase;
    logic [1:0] next_leg_phase;
    logic [1:0] mode_out;
    logic       touch_down;
    logic       latch_positions;
    logic       stance_left_ref;
  } status_t;

endpackage

/* rtl/bgps_core.sv */
// Gait state registers and the per-tick update logic.
module bgps_core import bgps_pkg::*; #(
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  logic [1:0]                    motion_cmd,
  input  logic                          start_request,
  input  logic signed [FZ_W-1:0]        fz_left,
  input  logic signed [FZ_W-1:0]        fz_right,
  input  logic [PHASE_FRAC_BITS:0]      phase_step,
  input  logic [PHASE_FRAC_BITS-1:0]    phi_switch_min,
  input  logic signed [FZ_W-1:0]        fz_switch_threshold,
  input  logic signed [FZ_W-1:0]        fz_stop_threshold,
  input  logic                          first_leg,
  output logic [PHASE_FRAC_BITS:0]      phase_res,
  output logic [STEPS_W-1:0]            steps_res,
  output status_t                       status_res
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam logic [PW:0] PHASE_ONE = (PW+1)'(1) << PHASE_FRAC_BITS;
  localparam logic [PHASE_FRAC_BITS-1:0] PHI_MAX =
    PHASE_FRAC_BITS'(((64'd1 << PHASE_FRAC_BITS) * 64'd99) / 64'd100);

  logic [PW-1:0]      phase_acc, phase_acc_next;
  logic [1:0]         stance_leg, stance_leg_next;
  logic [1:0]         planned_leg, planned_leg_next;
  logic [STEPS_W-1:0] step_counter, step_counter_next;
  logic touched_down, touched_down_next;
  logic stepping_enabled, stepping_enabled_next;
  logic initialized_flag, initialized_flag_next;
  logic walk_requested, walk_requested_next;
  logic latch;

  always_comb begin
    logic [1:0]                 mode;
    logic [1:0]                 first_code;
    logic [1:0]                 stance;
    logic [1:0]                 planned;
    logic [PHASE_FRAC_BITS-1:0] phi_min;
    logic [PW:0]                acc;
    logic [PW-1:0]              dphi;
    logic [STEPS_W-1:0]         cnt;
    logic                       td, en, init, wr, rdy, stepped;

    first_code = first_leg ? LEG_R : LEG_L;
    phi_min    = (phi_switch_min > PHI_MAX) ? PHI_MAX : phi_switch_min;
    mode       = (motion_cmd == 2'd3) ? MODE_STAND : motion_cmd;
    wr         = walk_requested | start_request;
    stance     = stance_leg;
    planned    = planned_leg;
    cnt        = step_counter;
    td         = touched_down;
    en         = stepping_enabled;
    init       = initialized_flag;
    acc        = {1'b0, phase_acc};
    dphi       = '0;
    latch      = 1'b0;
    stepped    = 1'b0;

    if (mode != MODE_STAND && step_counter == '0) begin
      stance = first_code;
    end

    if (mode == MODE_W2S) begin
      en = 1'b0;
      wr = 1'b0;
      if (td) begin
        mode = MODE_STAND;
      end
    end

    if (mode == MODE_STAND) begin
      acc     = '0;
      init    = 1'b0;
      en      = 1'b0;
      cnt     = '0;
      stance  = LEG_DS;
      planned = first_code;
    end else if (mode == MODE_WALK) begin
      en   = 1'b1;
      dphi = phase_step;
    end else if (stance != LEG_DS) begin
      dphi = phase_step;
    end

    // acc <= 1.0 on entry, so one extra bit holds the sum
    acc = acc + {1'b0, dphi};
    if (en && stance != LEG_DS) begin
      td = 1'b0;
    end

    if (!init && wr) begin
      init   = 1'b1;
      stance = first_code;
      latch  = 1'b1;
    end

    rdy = acc >= (PW+1)'(phi_min);
    if (en) begin
      if (stance == LEG_L && fz_right >= fz_switch_threshold && rdy) begin
        stance  = LEG_R;
        acc     = '0;
        latch   = 1'b1;
        stepped = 1'b1;
      end else if (stance == LEG_R && fz_left >= fz_switch_threshold && rdy) begin
        stance  = LEG_L;
        acc     = '0;
        latch   = 1'b1;
        stepped = 1'b1;
      end
    end else begin
      // last step: landing of either foot ends in double support
      if ((stance == LEG_L && fz_right >= fz_stop_threshold && rdy) ||
          (stance == LEG_R && fz_left >= fz_stop_threshold && rdy)) begin
        stepped = 1'b1;
        stance  = LEG_DS;
      end
      if (stance == LEG_DS) begin
        td  = 1'b1;
        acc = '0;
      end
    end

    if (stepped && cnt != '1) begin
      cnt = cnt + STEPS_W'(1);
    end

    if (acc >= PHASE_ONE) begin
      acc = PHASE_ONE;
    end
    if (stance == LEG_DS) begin
      acc = '0;
    end

    if (stance == LEG_L || stance == LEG_R) begin
      if (mode == MODE_WALK) begin
        planned = (stance == LEG_L) ? LEG_R : LEG_L;
      end else if (mode == MODE_W2S) begin
        planned = LEG_DS;
      end
    end else begin
      planned = en ? first_code : LEG_DS;
    end

    phase_acc_next        = acc[PW-1:0];
    stance_leg_next       = stance;
    planned_leg_next      = planned;
    step_counter_next     = cnt;
    touched_down_next     = td;
    stepping_enabled_next = en;
    initialized_flag_next = init;
    walk_requested_next   = wr;

    phase_res                  = acc[PW-1:0];
    steps_res                  = cnt;
    status_res.leg_phase       = stance;
    status_res.next_leg_phase  = planned;
    status_res.mode_out        = mode;
    status_res.touch_down      = td;
    status_res.latch_positions = latch;
    if (stance == LEG_L) begin
      status_res.stance_left_ref = 1'b1;
    end else if (stance == LEG_R) begin
      status_res.stance_left_ref = 1'b0;
    end else begin
      status_res.stance_left_ref = ~first_leg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc        <= '0;
      stance_leg       <= LEG_DS;
      planned_leg      <= LEG_L;
      step_counter     <= '0;
      touched_down     <= 1'b0;
      stepping_enabled <= 1'b0;
      initialized_flag <= 1'b0;
      walk_requested   <= 1'b0;
    end else if (step_en) begin
      phase_acc        <= phase_acc_next;
      stance_leg       <= stance_leg_next;
      planned_leg      <= planned_leg_next;
      step_counter     <= step_counter_next;
      touched_down     <= touched_down_next;
      stepping_enabled <= stepping_enabled_next;
      initialized_flag <= initialized_flag_next;
      walk_requested   <= walk_requested_next;
    end
  end

endmodule

/* rtl/biped_gait_phase_scheduler.sv */
// Top level of the biped gait phase scheduler: handshakes, registers, result stage.
//
//   channel  | direction | handshake             | word
//   ---------+-----------+-----------------------+----------------------------------
//   in       | to block  | in_valid / in_ready   | motion_cmd, start_request, fz_*
//   out      | from block| out_valid / out_ready | leg_phase ... stance_left_ref
//   cfg      | to block  | APB psel/penable      | five registers at 4*index
//
// One word per clock while out_ready is high; an accepted word passes from the input
// register into the result register, where out_valid presents it until it is taken.
// Reset: rst clears the gait state, both pipeline valids and the registers to
// their defaults. Stalls: a held result freezes the input register only while
// it is full; with out_ready high in_ready is always high.
module biped_gait_phase_scheduler import bgps_pkg::*; #(
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // input word
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   motion_cmd,
  input  logic                         start_request,
  input  logic signed [FZ_W-1:0]       fz_left,
  input  logic signed [FZ_W-1:0]       fz_right,
  // result word
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   leg_phase,
  output logic [1:0]                   next_leg_phase,
  output logic [PHASE_FRAC_BITS:0]     phase_out,
  output logic [1:0]                   mode_out,
  output logic                         touch_down,
  output logic [STEPS_W-1:0]           steps_taken,
  output logic                         latch_positions,
  output logic                         stance_left_ref,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  // defaults: 0.0025 per tick and 0.6, rounded to the phase grid
  localparam logic [PW-1:0] PHASE_STEP_RST =
    PW'(((64'd1 << PHASE_FRAC_BITS) * 64'd25 + 64'd5000) / 64'd10000);
  localparam logic [PHASE_FRAC_BITS-1:0] PHI_MIN_RST =
    PHASE_FRAC_BITS'(((64'd1 << PHASE_FRAC_BITS) * 64'd6 + 64'd5) / 64'd10);

  // ---------------- configuration registers ----------------
  logic [PW-1:0]              phase_step;
  logic [PHASE_FRAC_BITS-1:0] phi_switch_min;
  logic signed [FZ_W-1:0]     fz_switch_threshold;
  logic signed [FZ_W-1:0]     fz_stop_threshold;
  logic                       first_leg;
  logic [2:0]                 reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step          <= PHASE_STEP_RST;
      phi_switch_min      <= PHI_MIN_RST;
      fz_switch_threshold <= FZ_THRESH_RST;
      fz_stop_threshold   <= FZ_THRESH_RST;
      first_leg           <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PHASE_STEP: phase_step          <= pwdata[PW-1:0];
        REG_PHI_MIN:    phi_switch_min      <= pwdata[PHASE_FRAC_BITS-1:0];
        REG_FZ_SWITCH:  fz_switch_threshold <= pwdata[FZ_W-1:0];
        REG_FZ_STOP:    fz_stop_threshold   <= pwdata[FZ_W-1:0];
        REG_FIRST_LEG:  first_leg           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = CFG_DATA_W'(phase_step);
      REG_PHI_MIN:    prdata = CFG_DATA_W'(phi_switch_min);
      REG_FZ_SWITCH:  prdata = CFG_DATA_W'(fz_switch_threshold);
      REG_FZ_STOP:    prdata = CFG_DATA_W'(fz_stop_threshold);
      REG_FIRST_LEG:  prdata = CFG_DATA_W'(first_leg);
      default:        prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                   s1_valid;
  logic [1:0]             s1_cmd;
  logic                   s1_start;
  logic signed [FZ_W-1:0] s1_fzl, s1_fzr;
  logic                   advance;
  logic                   step_en;

  // result stage can take a word when empty or draining this cycle
  assign advance  = ~out_valid | out_ready;
  assign in_ready = ~s1_valid | advance;
  assign step_en  = s1_valid & advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= motion_cmd;
      s1_start <= start_request;
      s1_fzl   <= fz_left;
      s1_fzr   <= fz_right;
    end
  end

  // ---------------- gait update ----------------
  logic [PW-1:0]      phase_res;
  logic [STEPS_W-1:0] steps_res;
  status_t            status_res;
  status_t            status_q;

  bgps_core #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step_en             (step_en),
    .motion_cmd          (s1_cmd),
    .start_request       (s1_start),
    .fz_left             (s1_fzl),
    .fz_right            (s1_fzr),
    .phase_step          (phase_step),
    .phi_switch_min      (phi_switch_min),
    .fz_switch_threshold (fz_switch_threshold),
    .fz_stop_threshold   (fz_stop_threshold),
    .first_leg           (first_leg),
    .phase_res           (phase_res),
    .steps_res           (steps_res),
    .status_res          (status_res)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      phase_out   <= phase_res;
      steps_taken <= steps_res;
      status_q    <= status_res;
    end
  end

  assign leg_phase       = status_q.leg_phase;
  assign next_leg_phase  = status_q.next_leg_phase;
  assign mode_out        = status_q.mode_out;
  assign touch_down      = status_q.touch_down;
  assign latch_positions = status_q.latch_positions;
  assign stance_left_ref = status_q.stance_left_ref;

  // ---------------- checks ----------------
  a_ds_phase_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && leg_phase == LEG_DS |-> phase_out == '0)
    else $error("phase nonzero in double support");

  a_phase_le_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase_out <= (PW'(1) << PHASE_FRAC_BITS))
    else $error("phase above 1.0");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with output free");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("processed word not presented");

endmodule
